// File: src/rv32x_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
// Holds instruction class and funct3 codes and the item structs.
// No dependencies.
package rv32x_pkg;

    localparam logic [3:0] ACT_LUI    = 4'd0;
    localparam logic [3:0] ACT_AUIPC  = 4'd1;
    localparam logic [3:0] ACT_JAL    = 4'd2;
    localparam logic [3:0] ACT_JALR   = 4'd3;
    localparam logic [3:0] ACT_BRANCH = 4'd4;
    localparam logic [3:0] ACT_LOAD   = 4'd5;
    localparam logic [3:0] ACT_STORE  = 4'd6;
    localparam logic [3:0] ACT_OPIMM  = 4'd7;
    localparam logic [3:0] ACT_OP     = 4'd8;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;

    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;

    localparam logic [31:0] PC_STEP   = 32'd4;
    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

    typedef struct packed {
        logic [3:0]  action;
        logic [2:0]  funct3;
        logic        alt_bit;
        logic [31:0] imm;
        logic [5:0]  shamt;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
        logic [4:0]  dest_reg;
        logic [31:0] next_pc;
    } t_exec_in;

    typedef struct packed {
        logic [31:0] result;
        logic [31:0] store_data;
        logic [31:0] target_pc;
        logic        taken;
        logic [4:0]  dest_out;
        logic        illegal;
    } t_exec_out;

endpackage

// File: src/rv32x_exec_core.sv
// Combinational execute logic for one decoded RV32I instruction.
// Covers the ALU, branch compare, address and target adders.
// Depends on rv32x_pkg.
module rv32x_exec_core (
    input  rv32x_pkg::t_exec_in  i_item,
    output rv32x_pkg::t_exec_out o_item
);
    import rv32x_pkg::*;

    logic [31:0] imm_i;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] pc;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        is_op;
    logic        is_shift_imm;
    logic        use_alt;
    logic [4:0]  sh;
    logic [31:0] alu_out;
    logic [31:0] addr_sum;
    logic        br_eq;
    logic        br_lt;
    logic        br_ltu;
    logic        cond;

    assign imm_i = {{20{i_item.imm[11]}}, i_item.imm[11:0]};
    assign imm_b = {{19{i_item.imm[12]}}, i_item.imm[12:0]};
    assign imm_j = {{11{i_item.imm[20]}}, i_item.imm[20:0]};
    assign pc    = i_item.next_pc - PC_STEP;

    assign is_op        = (i_item.action == ACT_OP);
    assign is_shift_imm = (i_item.funct3 == F3_SLL) || (i_item.funct3 == F3_SR);
    assign opa          = i_item.rs1_value;

    always_comb begin
        if (is_op) begin
            opb     = i_item.rs2_value;
            use_alt = i_item.alt_bit;
        end else if (is_shift_imm) begin
            opb     = {26'd0, i_item.shamt};
            use_alt = i_item.alt_bit;
        end else begin
            opb     = imm_i;
            use_alt = 1'b0;
        end
    end

    assign sh = opb[4:0];

    always_comb begin
        case (i_item.funct3)
            F3_ADD:  alu_out = (is_op && use_alt) ? (opa - opb) : (opa + opb);
            F3_SLL:  alu_out = opa << sh;
            F3_SLT:  alu_out = {31'd0, $signed(opa) < $signed(opb)};
            F3_SLTU: alu_out = {31'd0, opa < opb};
            F3_XOR:  alu_out = opa ^ opb;
            F3_SR:   alu_out = use_alt ? 32'($signed(opa) >>> sh) : (opa >> sh);
            F3_OR:   alu_out = opa | opb;
            default: alu_out = opa & opb;
        endcase
    end

    assign addr_sum = i_item.rs1_value + imm_i;
    assign br_eq    = (i_item.rs1_value == i_item.rs2_value);
    assign br_lt    = ($signed(i_item.rs1_value) < $signed(i_item.rs2_value));
    assign br_ltu   = (i_item.rs1_value < i_item.rs2_value);

    always_comb begin
        o_item.result     = 32'd0;
        o_item.store_data = 32'd0;
        o_item.target_pc  = i_item.next_pc;
        o_item.taken      = 1'b0;
        o_item.dest_out   = 5'd0;
        o_item.illegal    = 1'b0;
        cond              = 1'b0;
        unique case (i_item.action)
            ACT_LUI: begin
                o_item.result   = i_item.imm;
                o_item.dest_out = i_item.dest_reg;
            end
            ACT_AUIPC: begin
                o_item.result   = pc + i_item.imm;
                o_item.dest_out = i_item.dest_reg;
            end
            ACT_JAL: begin
                o_item.result    = i_item.next_pc;
                o_item.dest_out  = i_item.dest_reg;
                o_item.taken     = 1'b1;
                o_item.target_pc = pc + imm_j;
            end
            ACT_JALR: begin
                o_item.result    = i_item.next_pc;
                o_item.dest_out  = i_item.dest_reg;
                o_item.taken     = 1'b1;
                o_item.target_pc = {addr_sum[31:1], 1'b0};
            end
            ACT_BRANCH: begin
                unique case (i_item.funct3)
                    F3_BEQ:  cond = br_eq;
                    F3_BNE:  cond = !br_eq;
                    F3_BLT:  cond = br_lt;
                    F3_BGE:  cond = !br_lt;
                    F3_BLTU: cond = br_ltu;
                    F3_BGEU: cond = !br_ltu;
                    default: o_item.illegal = 1'b1;
                endcase
                if (cond) begin
                    o_item.taken     = 1'b1;
                    o_item.target_pc = pc + imm_b;
                end
            end
            ACT_LOAD: begin
                unique case (i_item.funct3) inside
                    F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
                        o_item.result   = addr_sum;
                        o_item.dest_out = i_item.dest_reg;
                    end
                    default: o_item.illegal = 1'b1;
                endcase
            end
            ACT_STORE: begin
                unique case (i_item.funct3) inside
                    F3_SB: begin
                        o_item.result     = addr_sum;
                        o_item.store_data = i_item.rs2_value & BYTE_MASK;
                    end
                    F3_SH, F3_SW: begin
                        o_item.result     = addr_sum;
                        o_item.store_data = i_item.rs2_value;
                    end
                    default: o_item.illegal = 1'b1;
                endcase
            end
            ACT_OPIMM: begin
                if (is_shift_imm && i_item.shamt[5]) begin
                    o_item.illegal = 1'b1;
                end else begin
                    o_item.result   = alu_out;
                    o_item.dest_out = i_item.dest_reg;
                end
            end
            ACT_OP: begin
                o_item.result   = alu_out;
                o_item.dest_out = i_item.dest_reg;
            end
            default: o_item.illegal = 1'b1;
        endcase
    end

endmodule

// File: src/rv32i_execute_unit_top.sv
// Top level of the RV32I integer execute unit: input register, execute
// logic and result register with stream handshakes. Depends on rv32x_pkg
// and rv32x_exec_core.
//
//  Channel  | Direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+--------
//  s_axis   | in        | instruction operands (see port notes)  | action
//  m_axis   | out       | result, store data, target, taken, rd  | illegal
//
// An accepted item sits in the input register; it moves into the result
// register as soon as that register is empty or its result is leaving.
// One item can be accepted every cycle while the result is not stalled, since
// the whole execute path fits between the input and result registers.
// A stalled result holds its register; the input register keeps filling
// until both stages are full, then s_axis tready drops.
// Reset empties both stages.
module rv32i_execute_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // funct3, alt_bit, imm, shamt, rs1_value, rs2_value, dest_reg, next_pc, pad
    input  logic [143:0] i_s_axis_tdata,
    // action
    input  logic [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result, store_data, target_pc, taken, dest_out, pad
    output logic [103:0] o_m_axis_tdata,
    // illegal
    output logic [0:0]   o_m_axis_tuser
);
    import rv32x_pkg::*;

    logic      r_in_valid;
    t_exec_in  r_in;
    logic      r_out_valid;
    t_exec_out r_out;
    t_exec_out core_out;
    t_exec_in  n_in;
    logic      out_ready;
    logic      in_ready;

    assign out_ready = !r_out_valid || i_m_axis_tready;
    assign in_ready  = !r_in_valid || out_ready;

    assign n_in.action    = i_s_axis_tuser;
    assign n_in.funct3    = i_s_axis_tdata[2:0];
    assign n_in.alt_bit   = i_s_axis_tdata[3];
    assign n_in.imm       = i_s_axis_tdata[35:4];
    assign n_in.shamt     = i_s_axis_tdata[41:36];
    assign n_in.rs1_value = i_s_axis_tdata[73:42];
    assign n_in.rs2_value = i_s_axis_tdata[105:74];
    assign n_in.dest_reg  = i_s_axis_tdata[110:106];
    assign n_in.next_pc   = i_s_axis_tdata[142:111];

    rv32x_exec_core u_core (
        .i_item (r_in),
        .o_item (core_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in <= n_in;
        end
        if (out_ready && r_in_valid) begin
            r_out <= core_out;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.dest_out, r_out.taken, r_out.target_pc,
                              r_out.store_data, r_out.result};
    assign o_m_axis_tuser  = r_out.illegal;

`ifndef ASSERT_OFF
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_illegal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.illegal) |->
            (r_out.dest_out == 5'd0 && !r_out.taken && r_out.result == 32'd0
             && r_out.store_data == 32'd0))
        else $error("illegal item carries live result fields");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> o_m_axis_tvalid)
        else $error("valid item in input stage was lost");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for rv32i_execute_unit_top: drives decoded instructions,
// predicts each write-back item in place and compares it with the block's output.
// Depends on rv32x_pkg and the RTL of the execute unit.
`timescale 1ns / 1ps

module tb;
    import rv32x_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // funct3, alt_bit, imm, shamt, rs1_value, rs2_value, dest_reg, next_pc, pad
    logic [143:0] i_s_axis_tdata = '0;
    // action
    logic [3:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // result, store_data, target_pc, taken, dest_out, pad
    logic [103:0] o_m_axis_tdata;
    // illegal
    logic [0:0]   o_m_axis_tuser;

    t_exec_in  pending_instrs[$];
    t_exec_out expected_results[$];
    t_exec_in  drv_item = '0;
    logic      in_taken = 1'b0;
    int        src_idle_pct = 18;
    int        snk_idle_pct = 74;
    int        mismatches = 0;

    rv32i_execute_unit_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] sign_extend_at(logic [31:0] v, int sign_bit);
        logic [31:0] r;
        r = v;
        for (int i = sign_bit + 1; i < 32; i++) begin
            r[i] = v[sign_bit];
        end
        return r;
    endfunction

    function automatic logic [31:0] alu_calc(logic [2:0] f3, logic use_sub, logic use_sra,
                                             logic [31:0] a, logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            F3_ADD:  return use_sub ? a - b : a + b;
            F3_SLL:  return a << sh;
            F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: return {31'd0, a < b};
            F3_XOR:  return a ^ b;
            F3_SR:   return use_sra ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic t_exec_out predict_exec(t_exec_in x);
        t_exec_out   r;
        logic [31:0] pc;
        logic        cond;
        logic        bad;
        pc = x.next_pc - PC_STEP;
        r = '0;
        r.target_pc = x.next_pc;
        bad = 1'b0;
        cond = 1'b0;
        case (x.action)
            ACT_LUI: begin
                r.result = x.imm;
                r.dest_out = x.dest_reg;
            end
            ACT_AUIPC: begin
                r.result = pc + x.imm;
                r.dest_out = x.dest_reg;
            end
            ACT_JAL: begin
                r.result = x.next_pc;
                r.dest_out = x.dest_reg;
                r.taken = 1'b1;
                r.target_pc = pc + sign_extend_at(x.imm, 20);
            end
            ACT_JALR: begin
                r.result = x.next_pc;
                r.dest_out = x.dest_reg;
                r.taken = 1'b1;
                r.target_pc = (x.rs1_value + sign_extend_at(x.imm, 11)) & ~32'd1;
            end
            ACT_BRANCH: begin
                case (x.funct3)
                    F3_BEQ:  cond = x.rs1_value == x.rs2_value;
                    F3_BNE:  cond = x.rs1_value != x.rs2_value;
                    F3_BLT:  cond = $signed(x.rs1_value) < $signed(x.rs2_value);
                    F3_BGE:  cond = $signed(x.rs1_value) >= $signed(x.rs2_value);
                    F3_BLTU: cond = x.rs1_value < x.rs2_value;
                    F3_BGEU: cond = x.rs1_value >= x.rs2_value;
                    default: bad = 1'b1;
                endcase
                if (cond) begin
                    r.taken = 1'b1;
                    r.target_pc = pc + sign_extend_at(x.imm, 12);
                end
            end
            ACT_LOAD: begin
                case (x.funct3)
                    F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
                        r.result = x.rs1_value + sign_extend_at(x.imm, 11);
                        r.dest_out = x.dest_reg;
                    end
                    default: bad = 1'b1;
                endcase
            end
            ACT_STORE: begin
                case (x.funct3)
                    F3_SB, F3_SH, F3_SW: begin
                        r.result = x.rs1_value + sign_extend_at(x.imm, 11);
                        r.store_data = (x.funct3 == F3_SB) ? (x.rs2_value & BYTE_MASK)
                                                           : x.rs2_value;
                    end
                    default: bad = 1'b1;
                endcase
            end
            ACT_OPIMM: begin
                if (x.funct3 == F3_SLL || x.funct3 == F3_SR) begin
                    if (x.shamt[5]) begin
                        bad = 1'b1;
                    end else begin
                        r.result = alu_calc(x.funct3, 1'b0, x.alt_bit, x.rs1_value,
                                            {26'd0, x.shamt});
                    end
                end else begin
                    r.result = alu_calc(x.funct3, 1'b0, 1'b0, x.rs1_value,
                                        sign_extend_at(x.imm, 11));
                end
                r.dest_out = x.dest_reg;
            end
            ACT_OP: begin
                r.result = alu_calc(x.funct3, x.alt_bit, x.alt_bit, x.rs1_value, x.rs2_value);
                r.dest_out = x.dest_reg;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            r = '0;
            r.target_pc = x.next_pc;
            r.illegal = 1'b1;
        end
        return r;
    endfunction

    task automatic add_instr(logic [3:0] act, logic [2:0] f3, logic alt, logic [31:0] imm,
                             logic [5:0] shamt, logic [31:0] a, logic [31:0] b,
                             logic [4:0] rd, logic [31:0] npc);
        t_exec_in x;
        x.action = act;
        x.funct3 = f3;
        x.alt_bit = alt;
        x.imm = imm;
        x.shamt = shamt;
        x.rs1_value = a;
        x.rs2_value = b;
        x.dest_reg = rd;
        x.next_pc = npc;
        pending_instrs.push_back(x);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_exec_in random_instr();
        t_exec_in x;
        x.action = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        x.funct3 = 3'($urandom_range(0, 7));
        if (x.action == ACT_LOAD && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0: x.funct3 = F3_LB;
                1: x.funct3 = F3_LH;
                2: x.funct3 = F3_LW;
                3: x.funct3 = F3_LBU;
                default: x.funct3 = F3_LHU;
            endcase
        end
        if (x.action == ACT_STORE && $urandom_range(0, 3) != 0) begin
            x.funct3 = 3'($urandom_range(F3_SB, F3_SW));
        end
        x.alt_bit = 1'($urandom_range(0, 1));
        x.imm = ($urandom_range(0, 3) == 0) ? pick_word() : $urandom;
        x.shamt = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(32, 63))
                                              : 6'($urandom_range(0, 31));
        x.rs1_value = pick_word();
        x.rs2_value = ($urandom_range(0, 5) == 0) ? x.rs1_value : pick_word();
        x.dest_reg = 5'($urandom_range(0, 31));
        x.next_pc = ($urandom_range(0, 7) == 0) ? pick_word() : $urandom;
        return x;
    endfunction

    task automatic wait_drained();
        while (pending_instrs.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Driver: a new item goes out once the previous one has been accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                drv_item = pending_instrs.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {1'b0, drv_item.next_pc, drv_item.dest_reg,
                                   drv_item.rs2_value, drv_item.rs1_value, drv_item.shamt,
                                   drv_item.imm, drv_item.alt_bit, drv_item.funct3};
                i_s_axis_tuser <= drv_item.action;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_results.push_back(predict_exec(drv_item));
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual %h/%h", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                t_exec_out e;
                e = expected_results.pop_front();
                report_field("result", e.result, o_m_axis_tdata[31:0]);
                report_field("store_data", e.store_data, o_m_axis_tdata[63:32]);
                report_field("target_pc", e.target_pc, o_m_axis_tdata[95:64]);
                report_field("taken", {31'd0, e.taken}, {31'd0, o_m_axis_tdata[96]});
                report_field("dest_out", {27'd0, e.dest_out}, {27'd0, o_m_axis_tdata[101:97]});
                report_field("illegal", {31'd0, e.illegal}, {31'd0, o_m_axis_tuser[0]});
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_instr(ACT_LUI, F3_ADD, 1'b1, 32'hFFFF_FFFF, 6'd63, '0, '0, 5'd31, 32'h0);
        add_instr(ACT_AUIPC, F3_ADD, 1'b0, 32'h0000_0004, 6'd0, '1, '1, 5'd1, 32'h0);
        add_instr(ACT_JAL, F3_ADD, 1'b0, 32'h0010_0000, 6'd0, '0, '0, 5'd1, 32'h1000);
        add_instr(ACT_JALR, F3_ADD, 1'b0, 32'h0000_0801, 6'd0, 32'h0000_2000, '0, 5'd5,
                  32'h8000_0000);
        add_instr(ACT_BRANCH, F3_BEQ, 1'b0, 32'h0000_1FFE, 6'd0, 32'h1234, 32'h1234, 5'd7,
                  32'h400);
        add_instr(ACT_BRANCH, F3_BNE, 1'b0, 32'h0000_0010, 6'd0, 32'h1, 32'h2, 5'd7, 32'h400);
        add_instr(ACT_BRANCH, F3_BLT, 1'b0, 32'h0000_1000, 6'd0, 32'h8000_0000,
                  32'h7FFF_FFFF, 5'd2, 32'h4);
        add_instr(ACT_BRANCH, F3_BGE, 1'b0, 32'h0000_0FFE, 6'd0, 32'h8000_0000,
                  32'h7FFF_FFFF, 5'd2, 32'hFFFF_FFFC);
        add_instr(ACT_BRANCH, F3_BLTU, 1'b0, 32'h20, 6'd0, 32'h0, 32'hFFFF_FFFF, 5'd3, 32'h40);
        add_instr(ACT_BRANCH, F3_BGEU, 1'b0, 32'h20, 6'd0, 32'hFFFF_FFFF, 32'h0, 5'd3, 32'h40);
        add_instr(ACT_BRANCH, F3_SLT, 1'b0, 32'h20, 6'd0, 32'h5, 32'h5, 5'd3, 32'h40);
        add_instr(ACT_LOAD, F3_LW, 1'b0, 32'h0000_0800, 6'd0, 32'h1000, '0, 5'd9, 32'h80);
        add_instr(ACT_LOAD, F3_SLTU, 1'b0, 32'h4, 6'd0, 32'h1000, '0, 5'd9, 32'h80);
        add_instr(ACT_STORE, F3_SB, 1'b0, 32'hFFFF_F7FF, 6'd0, 32'h100, 32'hDEAD_BEEF, 5'd4,
                  32'h80);
        add_instr(ACT_STORE, F3_SH, 1'b1, 32'h7FF, 6'd0, 32'h100, 32'hDEAD_BEEF, 5'd4, 32'h80);
        add_instr(ACT_STORE, F3_SR, 1'b0, 32'h7FF, 6'd0, 32'h100, 32'hDEAD_BEEF, 5'd4, 32'h80);
        add_instr(ACT_OPIMM, F3_SLL, 1'b0, '0, 6'd31, 32'h0000_0003, '0, 5'd10, 32'h8);
        add_instr(ACT_OPIMM, F3_SR, 1'b1, '0, 6'd31, 32'h8000_0000, '0, 5'd10, 32'h8);
        add_instr(ACT_OPIMM, F3_SR, 1'b0, '0, 6'd32, 32'h8000_0000, '0, 5'd10, 32'h8);
        add_instr(ACT_OPIMM, F3_OR, 1'b1, 32'h0000_0F00, 6'd0, 32'h0000_00F0, '0, 5'd11, 32'h8);
        add_instr(ACT_OP, F3_ADD, 1'b1, '0, 6'd0, 32'h0, 32'h1, 5'd12, 32'h8);
        add_instr(ACT_OP, F3_SR, 1'b1, '0, 6'd0, 32'h8000_0000, 32'hFFFF_FFFF, 5'd13, 32'h8);
        add_instr(ACT_OP, F3_SR, 1'b0, '0, 6'd0, 32'h8000_0000, 32'h0000_0021, 5'd13, 32'h8);
        add_instr(ACT_OP, F3_SLT, 1'b0, '0, 6'd0, 32'hFFFF_FFFF, 32'h0, 5'd14, 32'h8);
        add_instr(4'hF, F3_AND, 1'b1, '1, 6'd63, '1, '1, 5'd31, '1);

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 483; n++) begin
                pending_instrs.push_back(random_instr());
            end
            // Wait until every queued and outstanding item has come out.
            wait_drained();
            case (phase)
                0: begin
                    src_idle_pct = 74;
                    snk_idle_pct = 18;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS rv32i_execute_unit_top");
        end else begin
            $display("FAIL rv32i_execute_unit_top");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL rv32i_execute_unit_top");
        $finish;
    end

endmodule

// File: sim.f
src/rv32x_pkg.sv
src/rv32x_exec_core.sv
src/rv32i_execute_unit_top.sv
tb/sv/tb.sv
